[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off while reset is low.
`define BMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bmp565 assertion failed");

// Same-cycle implication.
`define BMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `BMP_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// Next-cycle implication.
`define BMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  `BMP_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

[src/bmp565_pkg.sv]
// ----------------------------------------------------------------------------
// bmp565_pkg
// Shared types and constants of the BMP to RGB565 pixel stream block.
// ----------------------------------------------------------------------------
package bmp565_pkg;

  // Frame size in pixels
  localparam int unsigned SCREEN_WIDTH  = 240;
  localparam int unsigned SCREEN_HEIGHT = 135;

  // Configuration register indexes
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_X = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ORIGIN_Y = 1'd1;

  typedef enum logic [1:0] {
    KIND_PIXEL       = 2'd0,
    KIND_END         = 2'd1,
    KIND_BAD_SIG     = 2'd2,
    KIND_UNSUPPORTED = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        image_done;
  } result_t;

endpackage

[src/bmp565_in_reg.sv]
// ----------------------------------------------------------------------------
// bmp565_in_reg
// Input register: holds one byte item until the parser can take it.
// ----------------------------------------------------------------------------
module bmp565_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 tvalid_i,
  input  bmp565_pkg::in_item_t item_i,
  input  logic                 free_i,
  output logic                 tready_o,
  output logic                 step_o,
  output bmp565_pkg::in_item_t item_o
);
  import bmp565_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     accept;

  assign step_o   = valid_q & free_i;
  assign tready_o = ~valid_q | free_i;
  assign accept   = tvalid_i & tready_o;
  assign item_o   = item_q;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (step_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

endmodule

[src/bmp565_parser.sv]
// ----------------------------------------------------------------------------
// bmp565_parser
// Header parse, offset skip and pixel conversion; one byte per step.
// ----------------------------------------------------------------------------
module bmp565_parser (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [bmp565_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [bmp565_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                    step_i,
  input  bmp565_pkg::in_item_t                    item_i,
  output logic                                    res_valid_o,
  output bmp565_pkg::result_t                     res_o
);
  import bmp565_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_SKIP   = 2'd2;
  localparam logic [1:0] PH_PIXEL  = 2'd3;

  // header byte positions where a field completes
  localparam logic [31:0] HP_SIG    = 32'd1;
  localparam logic [31:0] HP_OFFSET = 32'd13;
  localparam logic [31:0] HP_WIDTH  = 32'd21;
  localparam logic [31:0] HP_HEIGHT = 32'd25;
  localparam logic [31:0] HP_PLANES = 32'd27;
  localparam logic [31:0] HP_BPP    = 32'd29;
  localparam logic [31:0] HP_COMP   = 32'd33;

  localparam logic [15:0] SIGNATURE  = 16'h4D42;
  localparam logic [15:0] PLANES_OK  = 16'd1;
  localparam logic [15:0] BPP_OK     = 16'd24;
  localparam logic [31:0] MIN_OFFSET = 32'd34;

  logic [15:0] origin_x_q, origin_y_q;
  logic [1:0]  phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] field_q, field_d;
  logic [31:0] offset_q, offset_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic [15:0] row_q, row_d;
  logic [15:0] col_q, col_d;
  logic [1:0]  chan_q, chan_d;
  logic [15:0] hold_q, hold_d;
  logic [1:0]  pad_q, pad_d;

  logic        go, fail_hit, start_px, row_end, img_done, pix_hit, pix_vis;
  kind_e       fail_kind;
  logic        origin_out;
  logic [7:0]  byte_in;
  logic [16:0] px_x;
  logic [15:0] px_y;
  logic [15:0] px_color;

  assign byte_in    = item_i.data_byte;
  assign origin_out = (origin_x_q >= 16'(SCREEN_WIDTH)) | (origin_y_q >= 16'(SCREEN_HEIGHT));

  // pixel path only runs in PH_PIXEL, where the live state is the registered state
  assign px_x     = {1'b0, origin_x_q} + {1'b0, col_q};
  assign px_y     = origin_y_q + height_q - 16'd1 - row_q;
  assign px_color = {byte_in[7:3], hold_q[15:10], hold_q[7:3]};
  assign pix_vis  = (px_x < 17'(SCREEN_WIDTH)) & (px_y < 16'(SCREEN_HEIGHT));

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q;
    field_d   = field_q;
    offset_d  = offset_q;
    width_d   = width_q;
    height_d  = height_q;
    row_d     = row_q;
    col_d     = col_q;
    chan_d    = chan_q;
    hold_d    = hold_q;
    pad_d     = pad_q;
    go        = 1'b0;
    fail_hit  = 1'b0;
    fail_kind = KIND_UNSUPPORTED;
    start_px  = 1'b0;
    row_end   = 1'b0;
    img_done  = 1'b0;
    pix_hit   = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (step_i) begin
      go = 1'b1;
      if (item_i.first_byte) begin
        if (origin_out) begin
          phase_d = PH_IDLE;
          go      = 1'b0;
        end else begin
          phase_d  = PH_HEADER;
          pos_d    = '0;
          field_d  = '0;
          offset_d = '0;
          width_d  = '0;
          height_d = '0;
          row_d    = '0;
          col_d    = '0;
          chan_d   = '0;
          hold_d   = '0;
          pad_d    = '0;
        end
      end
    end

    if (go) begin
      unique case (phase_d)
        PH_HEADER: begin
          field_d = {byte_in, field_d[31:8]};
          unique case (pos_d)
            HP_SIG: begin
              if (field_d[31:16] != SIGNATURE) begin
                fail_hit  = 1'b1;
                fail_kind = KIND_BAD_SIG;
              end
            end
            HP_OFFSET: offset_d = field_d;
            HP_WIDTH:  width_d  = field_d[15:0];
            HP_HEIGHT: height_d = field_d[15:0];
            HP_PLANES: fail_hit = (field_d[31:16] != PLANES_OK);
            HP_BPP:    fail_hit = (field_d[31:16] != BPP_OK);
            HP_COMP: begin
              if ((field_d != '0) || (offset_d < MIN_OFFSET)) begin
                fail_hit = 1'b1;
              end else if (offset_d == MIN_OFFSET) begin
                start_px = 1'b1;
              end else begin
                phase_d = PH_SKIP;
              end
            end
            default: ;
          endcase
          pos_d = pos_d + 32'd1;
        end
        PH_SKIP: begin
          pos_d = pos_d + 32'd1;
          if (pos_d == offset_d) begin
            start_px = 1'b1;
          end
        end
        PH_PIXEL: begin
          if (col_d >= width_d) begin
            // row padding
            pad_d = pad_d - 2'd1;
            if (pad_d == 2'd0) begin
              row_end = 1'b1;
            end
          end else if (chan_d == 2'd0) begin
            hold_d = {8'h00, byte_in};
            chan_d = 2'd1;
          end else if (chan_d == 2'd1) begin
            hold_d = {byte_in, hold_d[7:0]};
            chan_d = 2'd2;
          end else begin
            pix_hit = pix_vis;
            chan_d  = 2'd0;
            col_d   = col_d + 16'd1;
            if (col_d == width_d) begin
              pad_d = width_d[1:0];
              if (pad_d == 2'd0) begin
                row_end = 1'b1;
              end
            end
          end
          if (row_end) begin
            col_d = '0;
            row_d = row_d + 16'd1;
            if (row_d == height_d) begin
              phase_d  = PH_IDLE;
              img_done = 1'b1;
            end
          end
        end
        default: ;
      endcase

      if (fail_hit) begin
        phase_d = PH_IDLE;
      end

      if (start_px) begin
        if ((width_d == '0) || (height_d == '0)) begin
          phase_d  = PH_IDLE;
          img_done = 1'b1;
        end else begin
          phase_d = PH_PIXEL;
          row_d   = '0;
          col_d   = '0;
          chan_d  = '0;
          hold_d  = '0;
          pad_d   = '0;
        end
      end

      if (fail_hit) begin
        res_valid_o      = 1'b1;
        res_o.kind       = fail_kind;
        res_o.image_done = 1'b1;
      end else if (pix_hit) begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_PIXEL;
        res_o.pixel_x     = px_x[7:0];
        res_o.pixel_y     = px_y[7:0];
        res_o.pixel_color = px_color;
        res_o.image_done  = img_done;
      end else if (img_done) begin
        res_valid_o      = 1'b1;
        res_o.kind       = KIND_END;
        res_o.image_done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      origin_x_q <= '0;
      origin_y_q <= '0;
    end else begin
      phase_q <= phase_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_ORIGIN_X: origin_x_q <= cfg_data_i;
          REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        endcase
      end
    end
  end

  // re-initialized on a first byte whose origin lies inside the frame
  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    field_q  <= field_d;
    offset_q <= offset_d;
    width_q  <= width_d;
    height_q <= height_d;
    row_q    <= row_d;
    col_q    <= col_d;
    chan_q   <= chan_d;
    hold_q   <= hold_d;
    pad_q    <= pad_d;
  end

endmodule

[src/bmp565_out_reg.sv]
// ----------------------------------------------------------------------------
// bmp565_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module bmp565_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  bmp565_pkg::result_t res_i,
  input  logic                tready_i,
  output logic                free_o,
  output logic                tvalid_o,
  output bmp565_pkg::result_t res_o
);
  import bmp565_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // empty now or emptied at this edge
  assign free_o   = ~valid_q | tready_i;
  assign tvalid_o = valid_q;
  assign res_o    = res_q;
  assign valid_d  = free_o ? load_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[src/bmp24_stream_to_rgb565_pixels.sv]
// ----------------------------------------------------------------------------
// bmp24_stream_to_rgb565_pixels
// Takes a 24-bit uncompressed BMP file, one byte item per cycle while not
// stalled, and emits RGB565 pixel writes, cropped to the frame, plus end and
// error items. A byte enters the input register, is parsed once the output
// register is free, and any result lands in the output register. One byte is
// taken every cycle unless s_axis_tready falls, which it does only when both
// the input and output registers are full and m_axis_tready is low.
// Most bytes (header, skip, padding, blue and green) give no result item.
// ----------------------------------------------------------------------------
module bmp24_stream_to_rgb565_pixels (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [bmp565_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [bmp565_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // byte input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
  input  logic [0:0]                          s_axis_tuser,  // [0] first_byte
  // pixel output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [31:0]                         m_axis_tdata,  // [7:0] pixel_x,
                                                             // [15:8] pixel_y,
                                                             // [31:16] pixel_color
  output logic [1:0]                          m_axis_tuser,  // [1:0] kind
  output logic                                m_axis_tlast   // image_done
);
  import bmp565_pkg::*;

  in_item_t in_item, s1_item;
  result_t  res, out_res;
  logic     step, res_valid, out_free;

  assign in_item.data_byte  = s_axis_tdata;
  assign in_item.first_byte = s_axis_tuser[0];

  bmp565_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tvalid_i (s_axis_tvalid),
    .item_i   (in_item),
    .free_i   (out_free),
    .tready_o (s_axis_tready),
    .step_o   (step),
    .item_o   (s1_item)
  );

  bmp565_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .item_i      (s1_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmp565_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (res_valid),
    .res_i    (res),
    .tready_i (m_axis_tready),
    .free_o   (out_free),
    .tvalid_o (m_axis_tvalid),
    .res_o    (out_res)
  );

  assign m_axis_tdata = {out_res.pixel_color, out_res.pixel_y, out_res.pixel_x};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.image_done;

endmodule

[src/bmp565_checker.sv]
// ----------------------------------------------------------------------------
// bmp565_checker
// Port-level checks of the BMP to RGB565 block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp565_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  import bmp565_pkg::*;

  // stalled result holds
  `BMP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // end and error items always close the image
  `BMP_ASSERT_IMP(a_nonpix_done, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != KIND_PIXEL), m_axis_tlast)

  // end and error items carry no position or color
  `BMP_ASSERT_IMP(a_nonpix_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != KIND_PIXEL), m_axis_tdata == 32'd0)

  // a result appearing at an empty output stage comes from a byte accepted into the input register and then parsed
  `BMP_ASSERT_IMP(a_no_invent, clk_i, rst_ni, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind bmp24_stream_to_rgb565_pixels bmp565_checker u_bmp565_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
